[rtl/core/vt4x4_pkg.sv]
// Shared types, constants and helpers of the 4x4 vertex transform.
package vt4x4_pkg;

  // Fixed field and matrix geometry
  localparam int ELEM_W        = 32;
  localparam int REG_W         = 64;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 4;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;

  // Kind of item on the input stream
  typedef enum logic {
    CMD_VECTOR = 1'b0,
    CMD_POINT  = 1'b1
  } cmd_e;

  // One row result as it leaves a lane
  typedef struct packed {
    logic [ELEM_W-1:0] val;
    logic              sat;
  } lane_res_t;

  // Identity matrix word for register idx: row idx/2 holds columns 2*(idx%2) and 2*(idx%2)+1
  function automatic logic [REG_W-1:0] reset_word(input int idx, input int frac);
    logic [REG_W-1:0] one;
    int               row;
    one = REG_W'(1) << frac;
    row = idx / 2;
    if ((row / 2) == (idx % 2)) begin
      return one << (ELEM_W * (row % 2));
    end
    return '0;
  endfunction

endpackage

[rtl/core/vt4x4_lane.sv]
// One row lane: four products, a two-level registered adder tree, floor shift and saturation.
module vt4x4_lane #(
  parameter int FRAC_BITS = vt4x4_pkg::FRAC_BITS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 en_i,
  input  logic [vt4x4_pkg::NUM_COLS-1:0][vt4x4_pkg::ELEM_W-1:0] row_i,
  input  logic [vt4x4_pkg::NUM_COLS-1:0][vt4x4_pkg::ELEM_W-1:0] vec_i,
  output vt4x4_pkg::lane_res_t                                 res_o
);

  logic signed [vt4x4_pkg::ELEM_W-1:0] op_a [vt4x4_pkg::NUM_COLS];
  logic signed [vt4x4_pkg::ELEM_W-1:0] op_b [vt4x4_pkg::NUM_COLS];
  logic signed [vt4x4_pkg::PROD_W-1:0] prod_q [vt4x4_pkg::NUM_COLS];
  logic signed [vt4x4_pkg::PAIR_W-1:0] pair_q [2];
  logic signed [vt4x4_pkg::SUM_W-1:0]  sum_q;
  logic signed [vt4x4_pkg::SUM_W-1:0]  shifted;
  logic                                fits;

  // Split operands per column
  always_comb begin
    for (int c = 0; c < vt4x4_pkg::NUM_COLS; c++) begin
      op_a[c] = $signed(row_i[c]);
      op_b[c] = $signed(vec_i[c]);
    end
  end

  // Multiply, then add pairs, then add the two pair sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < vt4x4_pkg::NUM_COLS; c++) begin
        prod_q[c] <= op_a[c] * op_b[c];
      end
      pair_q[0] <= {prod_q[0][vt4x4_pkg::PROD_W-1], prod_q[0]}
                 + {prod_q[1][vt4x4_pkg::PROD_W-1], prod_q[1]};
      pair_q[1] <= {prod_q[2][vt4x4_pkg::PROD_W-1], prod_q[2]}
                 + {prod_q[3][vt4x4_pkg::PROD_W-1], prod_q[3]};
      sum_q     <= {pair_q[0][vt4x4_pkg::PAIR_W-1], pair_q[0]}
                 + {pair_q[1][vt4x4_pkg::PAIR_W-1], pair_q[1]};
    end
  end

  // Floor shift and clamp to the signed element range
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    fits    = (shifted[vt4x4_pkg::SUM_W-1:vt4x4_pkg::ELEM_W-1] == '0) ||
              (shifted[vt4x4_pkg::SUM_W-1:vt4x4_pkg::ELEM_W-1] == '1);
    res_o.sat = !fits;
    if (fits) begin
      res_o.val = shifted[vt4x4_pkg::ELEM_W-1:0];
    end else if (shifted[vt4x4_pkg::SUM_W-1]) begin
      res_o.val = {1'b1, {(vt4x4_pkg::ELEM_W-1){1'b0}}};
    end else begin
      res_o.val = {1'b0, {(vt4x4_pkg::ELEM_W-1){1'b1}}};
    end
  end

endmodule

[rtl/core/vt4x4_merge.sv]
// Merge stage: gathers the four lane results, masks row 3 for points, holds the output item.
module vt4x4_merge (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  adv_i,
  input  logic                                                  vld_i,
  input  vt4x4_pkg::cmd_e                                       cmd_i,
  input  vt4x4_pkg::lane_res_t [vt4x4_pkg::NUM_ROWS-1:0]        lane_i,
  output logic                                                  m_axis_tvalid,
  // fields from bit 0 up: out_x, out_y, out_z, out_w
  output logic [vt4x4_pkg::NUM_ROWS*vt4x4_pkg::ELEM_W-1:0]      m_axis_tdata,
  // fields from bit 0 up: overflow
  output logic                                                  m_axis_tuser
);

  logic                                                   valid_q;
  logic [vt4x4_pkg::NUM_ROWS-1:0][vt4x4_pkg::ELEM_W-1:0] data_d, data_q;
  logic                                                   ovf_d, ovf_q;
  logic                                                   is_point;

  // Combine lane results
  always_comb begin
    is_point = (cmd_i == vt4x4_pkg::CMD_POINT);
    ovf_d    = 1'b0;
    for (int r = 0; r < vt4x4_pkg::NUM_ROWS; r++) begin
      data_d[r] = lane_i[r].val;
      ovf_d     = ovf_d | lane_i[r].sat;
    end
    if (is_point) begin
      data_d[vt4x4_pkg::NUM_ROWS-1] = '0;
      ovf_d = lane_i[0].sat | lane_i[1].sat | lane_i[2].sat;
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
      ovf_q  <= ovf_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = ovf_q;

endmodule

[rtl/core/vertex_transform_4x4.sv]
// Top level of the 4x4 vertex transform: matrix registers, four row lanes and the merge stage.
// Pipeline: an accepted item passes the lane product, pair-sum and sum registers, then the merge output register.
// Throughput: one item per cycle; the whole pipeline moves together and halts only while
// the output register holds an item that is not taken.
// Reset: asynchronous, active low; clears all valid flags and loads the identity matrix.
// Matrix writes take effect on the next item accepted.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = vt4x4_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // fields from bit 0 up: in_x, in_y, in_z, in_w
  input  logic [vt4x4_pkg::NUM_COLS*vt4x4_pkg::ELEM_W-1:0] s_axis_tdata,
  // fields from bit 0 up: cmd
  input  logic                                             s_axis_tuser,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // fields from bit 0 up: out_x, out_y, out_z, out_w
  output logic [vt4x4_pkg::NUM_ROWS*vt4x4_pkg::ELEM_W-1:0] m_axis_tdata,
  // fields from bit 0 up: overflow
  output logic                                             m_axis_tuser,
  input  logic                                             cfg_valid_i,
  output logic                                             cfg_ready_o,
  input  logic [vt4x4_pkg::CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [vt4x4_pkg::REG_W-1:0]                      cfg_data_i
);

  localparam int RegIdxW = $clog2(vt4x4_pkg::NUM_REGS);
  localparam logic [vt4x4_pkg::ELEM_W-1:0] FxOne = vt4x4_pkg::ELEM_W'(1) << FRAC_BITS;

  logic [vt4x4_pkg::REG_W-1:0]                           mtx_q [vt4x4_pkg::NUM_REGS];
  logic [vt4x4_pkg::NUM_COLS-1:0][vt4x4_pkg::ELEM_W-1:0] vec;
  vt4x4_pkg::lane_res_t [vt4x4_pkg::NUM_ROWS-1:0]        lane_res;
  vt4x4_pkg::cmd_e                                       cmd_in;
  vt4x4_pkg::cmd_e                                       c1_q, c2_q, c3_q;
  logic                                                  v1_q, v2_q, v3_q;
  logic                                                  adv;
  logic                                                  in_acc;

  // Advance whenever the output register is free or being emptied
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;
  assign cfg_ready_o   = 1'b1;

  // Matrix registers; writes beyond the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vt4x4_pkg::NUM_REGS; i++) begin
        mtx_q[i] <= vt4x4_pkg::reset_word(i, FRAC_BITS);
      end
    end else if (cfg_valid_i &&
                 (cfg_index_i < vt4x4_pkg::CFG_IDX_W'(vt4x4_pkg::NUM_REGS))) begin
      mtx_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Build the input vector; a point takes w as one
  always_comb begin
    cmd_in = vt4x4_pkg::cmd_e'(s_axis_tuser);
    for (int c = 0; c < vt4x4_pkg::NUM_COLS; c++) begin
      vec[c] = s_axis_tdata[c*vt4x4_pkg::ELEM_W +: vt4x4_pkg::ELEM_W];
    end
    if (cmd_in == vt4x4_pkg::CMD_POINT) begin
      vec[vt4x4_pkg::NUM_COLS-1] = FxOne;
    end
  end

  // Track item valid flags alongside the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= cmd_in;
      c2_q <= c1_q;
      c3_q <= c2_q;
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < vt4x4_pkg::NUM_ROWS; r++) begin : g_lane
    vt4x4_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .row_i ({mtx_q[2*r+1], mtx_q[2*r]}),
      .vec_i (vec),
      .res_o (lane_res[r])
    );
  end

  vt4x4_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .vld_i         (v3_q),
    .cmd_i         (c3_q),
    .lane_i        (lane_res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // A finished item in the last lane stage reaches the output when the pipe advances
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q) |=> m_axis_tvalid)
    else $error("item lost between lane stage and output");

  // A point item leaves with a zero w component
  a_point_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q && (c3_q == vt4x4_pkg::CMD_POINT)) |=>
      (m_axis_tdata[vt4x4_pkg::NUM_ROWS*vt4x4_pkg::ELEM_W-1 -: vt4x4_pkg::ELEM_W] == '0))
    else $error("point item has nonzero w");

  // A stalled pipe keeps its in-flight items
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q)))
    else $error("in-flight item moved during stall");

endmodule

[verif/vt4x4_xform_checker.sv]
// Checker of the 4x4 vertex transform: tracks the matrix, predicts each result and compares it.
module vt4x4_xform_checker
  import vt4x4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // fields from bit 0 up: in_x, in_y, in_z, in_w
  input  logic [NUM_COLS*ELEM_W-1:0]   s_axis_tdata,
  // fields from bit 0 up: cmd
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // fields from bit 0 up: out_x, out_y, out_z, out_w
  input  logic [NUM_ROWS*ELEM_W-1:0]   m_axis_tdata,
  // fields from bit 0 up: overflow
  input  logic                         m_axis_tuser,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [REG_W-1:0]             cfg_data_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RegIdxW = $clog2(NUM_REGS);

  typedef struct packed {
    logic [ELEM_W-1:0] x;
    logic [ELEM_W-1:0] y;
    logic [ELEM_W-1:0] z;
    logic [ELEM_W-1:0] w;
    logic              ovf;
  } vertex_out_t;

  logic [REG_W-1:0] matrix_q [NUM_REGS];
  vertex_out_t      expected_vertices [$];
  int               error_count = 0;

  // Element (row, col): two per register word, lower column in the low half
  function automatic logic signed [ELEM_W-1:0] element(input int row, input int col);
    logic [REG_W-1:0] word;
    word = matrix_q[row * 2 + col / 2];
    return (col % 2 == 1) ? word[REG_W-1:ELEM_W] : word[ELEM_W-1:0];
  endfunction

  // One row: exact wide sum of four products, floor shift, clamp to 32 bits
  function automatic logic [ELEM_W-1:0] dot_row(input int row,
                                                input logic signed [ELEM_W-1:0] vx, vy, vz, vw,
                                                output logic clamped);
    logic signed [ELEM_W-1:0] vec [NUM_COLS];
    logic signed [PROD_W-1:0] e_wide;
    logic signed [PROD_W-1:0] v_wide;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  scaled;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = vw;
    acc = '0;
    for (int col = 0; col < NUM_COLS; col++) begin
      e_wide = element(row, col);
      v_wide = vec[col];
      prod   = e_wide * v_wide;
      acc    = acc + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    scaled  = acc >>> FRAC_BITS;
    clamped = (scaled[SUM_W-1:ELEM_W-1] != '0) && (scaled[SUM_W-1:ELEM_W-1] != '1);
    if (!clamped) begin
      return scaled[ELEM_W-1:0];
    end
    return scaled[SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
  endfunction

  // Full result of one item; a point has w of one and leaves out_w at zero
  function automatic vertex_out_t transform_vertex(input cmd_e cmd,
                                                   input logic [NUM_COLS*ELEM_W-1:0] data);
    vertex_out_t              res;
    logic signed [ELEM_W-1:0] vw;
    logic                     sx, sy, sz, sw;
    vw = (cmd == CMD_POINT) ? (ELEM_W'(1) << FRAC_BITS) : data[4*ELEM_W-1:3*ELEM_W];
    res.x = dot_row(0, data[ELEM_W-1:0], data[2*ELEM_W-1:ELEM_W], data[3*ELEM_W-1:2*ELEM_W],
                    vw, sx);
    res.y = dot_row(1, data[ELEM_W-1:0], data[2*ELEM_W-1:ELEM_W], data[3*ELEM_W-1:2*ELEM_W],
                    vw, sy);
    res.z = dot_row(2, data[ELEM_W-1:0], data[2*ELEM_W-1:ELEM_W], data[3*ELEM_W-1:2*ELEM_W],
                    vw, sz);
    res.w = '0;
    sw    = 1'b0;
    if (cmd == CMD_VECTOR) begin
      res.w = dot_row(3, data[ELEM_W-1:0], data[2*ELEM_W-1:ELEM_W], data[3*ELEM_W-1:2*ELEM_W],
                      vw, sw);
    end
    res.ovf = sx | sy | sz | sw;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [ELEM_W-1:0] want, got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endfunction

  // Track the matrix, retire results against expectations, then queue new ones
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_out_t want;
    if (!rst_ni) begin
      expected_vertices.delete();
      for (int k = 0; k < NUM_REGS; k++) begin
        matrix_q[k] = '0;
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
        matrix_q[2 * r + r / 2] = REG_W'(1) << (FRAC_BITS + ELEM_W * (r % 2));
      end
    end else begin
      // drop writes to an index beyond the last register
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_REGS) begin
        matrix_q[cfg_index_i[RegIdxW-1:0]] = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_vertices.size() == 0) begin
          error_count++;
          $display("%0t: result expected none, got %h / %b", $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_vertices.pop_front();
          check_field("out_x", want.x, m_axis_tdata[ELEM_W-1:0]);
          check_field("out_y", want.y, m_axis_tdata[2*ELEM_W-1:ELEM_W]);
          check_field("out_z", want.z, m_axis_tdata[3*ELEM_W-1:2*ELEM_W]);
          check_field("out_w", want.w, m_axis_tdata[4*ELEM_W-1:3*ELEM_W]);
          check_field("overflow", ELEM_W'(want.ovf), ELEM_W'(m_axis_tuser));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vertices.push_back(transform_vertex(cmd_e'(s_axis_tuser), s_axis_tdata));
      end
    end
    pending_o <= expected_vertices.size();
    errors_o  <= error_count;
  end

endmodule

[verif/tb_vertex_transform_4x4.sv]
// Testbench top of the 4x4 vertex transform: clock, reset, stimulus, watchdog and verdict.
module tb_vertex_transform_4x4;
  timeunit 1ns;
  timeprecision 1ps;

  import vt4x4_pkg::*;

  localparam int                LATENCY     = 3;
  localparam int                HOLD_CYCLES = 64;
  localparam int                QUIET_LIMIT = 1000;
  localparam int                PHASES      = 7;
  localparam int                PHASE_ITEMS = 90;
  localparam logic [ELEM_W-1:0] MAX_VAL     = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] MIN_VAL     = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] ONE_VAL     = ELEM_W'(1) << FRAC_BITS_DEF;
  localparam logic [ELEM_W-1:0] TINY_VAL    = 32'h0000_0001;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // fields from bit 0 up: in_x, in_y, in_z, in_w
  logic [NUM_COLS*ELEM_W-1:0] s_axis_tdata  = '0;
  // fields from bit 0 up: cmd
  logic                       s_axis_tuser  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // fields from bit 0 up: out_x, out_y, out_z, out_w
  logic [NUM_ROWS*ELEM_W-1:0] m_axis_tdata;
  // fields from bit 0 up: overflow
  logic                       m_axis_tuser;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i   = '0;
  logic [REG_W-1:0]           cfg_data_i    = '0;

  int               errors;
  int               pending;
  logic             idle_on       = 1'b1;
  int               hold_requests = 0;
  int               quiet_cycles  = 0;
  logic [REG_W-1:0] matrix_words [NUM_REGS];

  vertex_transform_4x4 #(
    .FRAC_BITS(FRAC_BITS_DEF)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  vt4x4_xform_checker #(
    .FRAC_BITS(FRAC_BITS_DEF)
  ) xform_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 5)) : 0;
  endfunction

  // Mostly plain values, now and then an extreme; narrow values stay within +/-8.0
  function automatic logic [ELEM_W-1:0] pick_value(input bit wide);
    case ($urandom_range(0, 11))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2:       return '0;
      default: return wide ? ELEM_W'($urandom())
                           : ELEM_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic void fill_matrix(input logic [REG_W-1:0] word);
    foreach (matrix_words[k]) begin
      matrix_words[k] = word;
    end
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_vertex(input cmd_e cmd, input logic [ELEM_W-1:0] x, y, z, w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Drain, then write all matrix registers back to back, optionally one unused index too
  task automatic program_matrix(input bit poke_unused);
    quiesce();
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(k);
      cfg_data_i  <= matrix_words[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    if (poke_unused) begin
      cfg_index_i <= CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
      cfg_data_i  <= {$urandom(), $urandom()};
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, and a long hold-off whenever one is requested
  initial begin : result_sink
    int stall;
    int holds_served;
    holds_served = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (holds_served != hold_requests) begin
        stall = HOLD_CYCLES;
        holds_served++;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog: end the run after too long without any item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    bit wide;
    bit vec_wide;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity from reset: extremes, point with ignored w, mixed signs
    send_vertex(CMD_VECTOR, '0, '0, '0, '0);
    send_vertex(CMD_VECTOR, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
    send_vertex(CMD_VECTOR, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
    send_vertex(CMD_POINT, ONE_VAL, 32'hFFFD_8000, 32'h0003_4000, MAX_VAL);
    send_vertex(CMD_POINT, MIN_VAL, MAX_VAL, 32'hFFFF_FFFF, MIN_VAL);
    send_vertex(CMD_VECTOR, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678, 32'h8000_0001);

    // Every element at the positive extreme: saturation both ways
    fill_matrix({MAX_VAL, MAX_VAL});
    program_matrix(1'b1);
    send_vertex(CMD_VECTOR, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
    send_vertex(CMD_VECTOR, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
    send_vertex(CMD_POINT, MAX_VAL, MAX_VAL, MAX_VAL, '0);
    send_vertex(CMD_VECTOR, TINY_VAL, '0, '0, '0);

    // Every element at the negative extreme: sums beyond 64 bits
    fill_matrix({MIN_VAL, MIN_VAL});
    program_matrix(1'b0);
    send_vertex(CMD_VECTOR, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
    send_vertex(CMD_VECTOR, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
    send_vertex(CMD_POINT, MIN_VAL, MIN_VAL, MIN_VAL, MAX_VAL);

    // Smallest elements: floor rounding of tiny negative sums
    fill_matrix({TINY_VAL, TINY_VAL});
    program_matrix(1'b0);
    send_vertex(CMD_VECTOR, 32'hFFFF_FFFF, '0, '0, '0);
    send_vertex(CMD_VECTOR, TINY_VAL, '0, '0, '0);
    send_vertex(CMD_POINT, 32'hFFFF_FFFF, '0, '0, MIN_VAL);
    send_vertex(CMD_VECTOR, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);

    // Alternating extremes: large products that cancel
    fill_matrix({MIN_VAL, MAX_VAL});
    program_matrix(1'b1);
    send_vertex(CMD_VECTOR, MAX_VAL, MAX_VAL, MIN_VAL, MIN_VAL);
    send_vertex(CMD_POINT, MAX_VAL, MIN_VAL, MAX_VAL, '0);

    // Random phases, each with its own matrix; the last goes back to identity
    for (int p = 0; p < PHASES; p++) begin
      wide = p % 2;
      foreach (matrix_words[k]) begin
        matrix_words[k] = (p == PHASES - 1) ? reset_word(k, FRAC_BITS_DEF)
                                            : {pick_value(wide), pick_value(wide)};
      end
      program_matrix($urandom_range(0, 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 30 == 0) begin
          idle_on <= ($urandom_range(0, 3) != 0);
        end
        // hold the result side off while items keep coming, so the input stalls
        if (p == 1 && i == 10) begin
          idle_on       <= 1'b0;
          hold_requests <= hold_requests + 1;
        end
        if (p == 4 && i == 45) begin
          quiesce();
        end
        vec_wide = wide ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0);
        vec_wide = wide ^ vec_wide ^ wide;
        send_vertex(cmd_e'($urandom_range(0, 1)), pick_value(vec_wide), pick_value(vec_wide),
                    pick_value(vec_wide), pick_value(vec_wide));
      end
    end

    quiesce();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
